/* hw/rtl/ficl_pkg.sv */
// ----------------------------------------------------------------------------
// Fixed capacity insert list package
// Shared codes, field widths and the cell control type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ficl_pkg;

	localparam int VAL_W = 32;
	localparam int POS_W = 6;
	localparam int CNT_W = 7;
	localparam int REQ_W = 2;
	localparam int ST_W  = 2;

	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 48;
	localparam int S_TUSER_W = 2;
	localparam int M_TUSER_W = 2;
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;

	localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
	localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
	localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;
	localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd3;

	localparam logic [ST_W-1:0] ST_OK     = 2'd0;
	localparam logic [ST_W-1:0] ST_BADPOS = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL   = 2'd2;
	localparam logic [ST_W-1:0] ST_EMPTY  = 2'd3;

	localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;
	localparam logic [CNT_W-1:0] CNT_MAX   = 7'd127;

	localparam int RD_GROUP = 8;

	typedef struct packed {
		logic                    ins_en;
		logic                    rem_en;
		logic [POS_W-1:0]        pos;
		logic signed [VAL_W-1:0] ins_value;
	} cell_ctrl_t;

endpackage

/* hw/rtl/ficl_cell.sv */
// ----------------------------------------------------------------------------
// List cell
// Holds one list entry and shifts it to or from its neighbors.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ficl_cell #(
	parameter int INDEX = 0
) (
	input  logic                             clk,
	input  ficl_pkg::cell_ctrl_t             ctrl,
	input  logic signed [ficl_pkg::VAL_W-1:0] left_value,
	input  logic signed [ficl_pkg::VAL_W-1:0] right_value,
	output logic signed [ficl_pkg::VAL_W-1:0] cell_value,
	output logic signed [ficl_pkg::VAL_W-1:0] rd_value
);
	import ficl_pkg::*;

	localparam bit               HIGH_CELL = (INDEX >= (1 << POS_W));
	localparam logic [POS_W-1:0] IDX       = POS_W'(INDEX);

	logic signed [VAL_W-1:0] value_q;
	logic                    hit;
	logic                    above;

	assign hit   = !HIGH_CELL && (IDX == ctrl.pos);
	assign above = HIGH_CELL || (IDX > ctrl.pos);

	always_ff @(posedge clk) begin
		if (ctrl.ins_en) begin
			if (hit) begin
				value_q <= ctrl.ins_value;
			end else if (above) begin
				value_q <= left_value;
			end
		end else if (ctrl.rem_en) begin
			if (hit || above) begin
				value_q <= right_value;
			end
		end
	end

	assign cell_value = value_q;
	assign rd_value   = hit ? value_q : '0;

endmodule

/* hw/rtl/fixed_capacity_insert_list_core.sv */
// ----------------------------------------------------------------------------
// Fixed capacity insert list core
// An ordered list of signed 32-bit entries held in a row of cells. Each
// request inserts, removes, reads or clears, and returns one result item
// with a status, the value read, the entry count and the full and empty
// flags. The block takes one item per cycle while the result side does not
// stall. The cells shift when an item is accepted, and the read goes
// through a two-level registered OR tree over the first 64 cells. The
// capacity register at byte address 0 is clamped to 1..MAX_DEPTH and must
// only be written while no item is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fixed_capacity_insert_list_core #(
	parameter int MAX_DEPTH = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// s_tdata: position [5:0], elem_value [37:6], zero pad [39:38]
	input  logic [ficl_pkg::S_TDATA_W-1:0]     s_tdata,
	// s_tuser: req_type [1:0]
	input  logic [ficl_pkg::S_TUSER_W-1:0]     s_tuser,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// m_tdata: status [1:0], read_value [33:2], entry_count [40:34], pad [47:41]
	output logic [ficl_pkg::M_TDATA_W-1:0]     m_tdata,
	// m_tuser: is_full [0], is_empty [1]
	output logic [ficl_pkg::M_TUSER_W-1:0]     m_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [ficl_pkg::PADDR_W-1:0]       paddr,
	input  logic [ficl_pkg::PDATA_W-1:0]       pwdata,
	output logic [ficl_pkg::PDATA_W-1:0]       prdata,
	output logic                               pready
);
	import ficl_pkg::*;

	localparam int RD_CELLS = (MAX_DEPTH < (1 << POS_W)) ? MAX_DEPTH : (1 << POS_W);
	localparam int NGRP     = (RD_CELLS + RD_GROUP - 1) / RD_GROUP;
	localparam logic [CNT_W-1:0] CAP_LIMIT =
		(MAX_DEPTH > 127) ? CNT_MAX : CNT_W'(MAX_DEPTH);

	logic [CNT_W-1:0] cap_q;
	logic [CNT_W-1:0] eff_cap;
	logic [CNT_W-1:0] count_q;

	logic                    accept;
	logic                    move_s1;
	logic [REQ_W-1:0]        req;
	logic [POS_W-1:0]        pos;
	logic [CNT_W-1:0]        pos_ext;
	logic signed [VAL_W-1:0] in_value;

	logic [ST_W-1:0]  st;
	logic [CNT_W-1:0] next_count;
	logic             rd_ok;
	logic             ins_ok;
	logic             rem_ok;

	cell_ctrl_t ctrl;

	logic signed [VAL_W-1:0] cell_val [MAX_DEPTH];
	logic signed [VAL_W-1:0] cell_rd  [MAX_DEPTH];
	logic signed [VAL_W-1:0] grp_or   [NGRP];
	logic signed [VAL_W-1:0] final_or;

	logic                    v_s1;
	logic [ST_W-1:0]         st_s1;
	logic [CNT_W-1:0]        count_s1;
	logic                    full_s1;
	logic                    empty_s1;
	logic                    rd_ok_s1;
	logic signed [VAL_W-1:0] grp_s1 [NGRP];

	logic                    m_valid_q;
	logic [ST_W-1:0]         st_q;
	logic signed [VAL_W-1:0] rd_value_q;
	logic [CNT_W-1:0]        count_out_q;
	logic                    full_q;
	logic                    empty_q;

	// Configuration port.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {{(PDATA_W-CNT_W){1'b0}}, cap_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
			cap_q <= pwdata[CNT_W-1:0];
		end
	end

	always_comb begin
		if (cap_q == '0) begin
			eff_cap = CNT_W'(1);
		end else if (cap_q > CAP_LIMIT) begin
			eff_cap = CAP_LIMIT;
		end else begin
			eff_cap = cap_q;
		end
	end

	// Request decode and status.
	assign req      = s_tuser[REQ_W-1:0];
	assign pos      = s_tdata[POS_W-1:0];
	assign in_value = s_tdata[POS_W +: VAL_W];
	assign pos_ext  = {1'b0, pos};

	assign move_s1  = v_s1 && (!m_valid_q || m_tready);
	assign s_tready = !v_s1 || move_s1;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		st         = ST_OK;
		next_count = count_q;
		rd_ok      = 1'b0;
		ins_ok     = 1'b0;
		rem_ok     = 1'b0;
		case (req)
			REQ_INSERT: begin
				if (pos_ext >= eff_cap) begin
					st = ST_BADPOS;
				end else if (count_q >= eff_cap) begin
					st = ST_FULL;
				end else if (pos_ext > count_q) begin
					st = ST_BADPOS;
				end else begin
					ins_ok     = 1'b1;
					next_count = count_q + CNT_W'(1);
				end
			end
			REQ_REMOVE: begin
				if (pos_ext >= eff_cap) begin
					st = ST_BADPOS;
				end else if (count_q == '0) begin
					st = ST_EMPTY;
				end else if (pos_ext >= count_q) begin
					st = ST_BADPOS;
				end else begin
					rem_ok     = 1'b1;
					next_count = count_q - CNT_W'(1);
				end
			end
			REQ_READ: begin
				if (count_q == '0) begin
					st = ST_EMPTY;
				end else if (pos_ext >= count_q) begin
					st = ST_BADPOS;
				end else begin
					rd_ok = 1'b1;
				end
			end
			REQ_CLEAR: begin
				next_count = '0;
			end
			default: begin
				st = ST_OK;
			end
		endcase
	end

	assign ctrl.ins_en    = accept && ins_ok;
	assign ctrl.rem_en    = accept && rem_ok;
	assign ctrl.pos       = pos;
	assign ctrl.ins_value = in_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= next_count;
		end
	end

	// Row of cells.
	for (genvar i = 0; i < MAX_DEPTH; i++) begin : g_cell
		logic signed [VAL_W-1:0] left_v;
		logic signed [VAL_W-1:0] right_v;
		if (i == 0) begin : g_first
			assign left_v = '0;
		end else begin : g_mid_l
			assign left_v = cell_val[i-1];
		end
		if (i == MAX_DEPTH - 1) begin : g_last
			assign right_v = '0;
		end else begin : g_mid_r
			assign right_v = cell_val[i+1];
		end
		ficl_cell #(
			.INDEX(i)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.left_value (left_v),
			.right_value(right_v),
			.cell_value (cell_val[i]),
			.rd_value   (cell_rd[i])
		);
	end

	// Read tree, first level.
	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_or[g] = '0;
			for (int k = 0; k < RD_GROUP; k++) begin
				if (g * RD_GROUP + k < RD_CELLS) begin
					grp_or[g] = grp_or[g] | cell_rd[g * RD_GROUP + k];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (move_s1) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			st_s1    <= st;
			count_s1 <= next_count;
			full_s1  <= (next_count >= eff_cap);
			empty_s1 <= (next_count == '0);
			rd_ok_s1 <= rd_ok;
			for (int g = 0; g < NGRP; g++) begin
				grp_s1[g] <= grp_or[g];
			end
		end
	end

	// Read tree, second level, and output register.
	always_comb begin
		final_or = '0;
		for (int g = 0; g < NGRP; g++) begin
			final_or = final_or | grp_s1[g];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (move_s1) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			st_q        <= st_s1;
			rd_value_q  <= rd_ok_s1 ? final_or : '0;
			count_out_q <= count_s1;
			full_q      <= full_s1;
			empty_q     <= empty_s1;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(M_TDATA_W-ST_W-VAL_W-CNT_W){1'b0}}, count_out_q, rd_value_q, st_q};
	assign m_tuser  = {empty_q, full_q};

endmodule

/* hw/rtl/ficl_checker.sv */
// ----------------------------------------------------------------------------
// Fixed capacity insert list checker
// Port-level assertions on the result stream, bound to the core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ficl_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic [ficl_pkg::M_TDATA_W-1:0] m_tdata,
	input logic [ficl_pkg::M_TUSER_W-1:0] m_tuser,
	input logic                           m_tvalid,
	input logic                           m_tready
);
	import ficl_pkg::*;

	logic [ST_W-1:0]  st;
	logic [VAL_W-1:0] rdv;
	logic [CNT_W-1:0] cnt;

	assign st  = m_tdata[ST_W-1:0];
	assign rdv = m_tdata[ST_W +: VAL_W];
	assign cnt = m_tdata[ST_W + VAL_W +: CNT_W];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result item changed while stalled");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser[1] == (cnt == '0)))
		else $error("empty flag disagrees with entry count");

	a_rd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (st != ST_OK) |-> (rdv == '0))
		else $error("failed request returned a nonzero value");

	a_full_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("list reported both full and empty");

	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (st == ST_EMPTY) |-> m_tuser[1])
		else $error("empty status on a list that holds entries");

endmodule

bind fixed_capacity_insert_list_core ficl_checker u_ficl_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready)
);

/* test/ficl_result_checker.sv */
// ----------------------------------------------------------------------------
// Insert list result checker
// Watches the request, result and register channels of the insert list core.
// It keeps its own copy of the list, the entry count and the capacity. For
// every accepted request it predicts the result item and queues it. Every
// accepted result item is compared field by field with the oldest prediction.
// Register reads are checked against the last value written. Failures are
// counted and handed to the testbench top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ficl_result_checker #(
	parameter int                           DEPTH    = 64,
	parameter logic [ficl_pkg::PADDR_W-1:0] CAP_ADDR = '0
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [ficl_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic [ficl_pkg::S_TUSER_W-1:0] s_tuser,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [ficl_pkg::M_TDATA_W-1:0] m_tdata,
	input  logic [ficl_pkg::M_TUSER_W-1:0] m_tuser,
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [ficl_pkg::PADDR_W-1:0]   paddr,
	input  logic [ficl_pkg::PDATA_W-1:0]   pwdata,
	input  logic [ficl_pkg::PDATA_W-1:0]   prdata,
	input  logic                           pready,
	output int                             fail_total,
	output int                             outstanding,
	output logic [ficl_pkg::CNT_W-1:0]     level
);
	import ficl_pkg::*;

	typedef struct packed {
		logic [ST_W-1:0]  status;
		logic [VAL_W-1:0] value;
		logic [CNT_W-1:0] count;
		logic             full;
		logic             empty;
	} outcome_t;

	logic [VAL_W-1:0] entries [DEPTH];
	logic [CNT_W-1:0] n_held;
	logic [CNT_W-1:0] cap_raw;
	outcome_t         expected_q [$];

	function automatic logic [CNT_W-1:0] usable_cap(input logic [CNT_W-1:0] raw);
		if (raw == '0)
			return CNT_W'(1);
		if (raw > DEPTH)
			return CNT_W'(DEPTH);
		return raw;
	endfunction

	task automatic apply_request(input logic [REQ_W-1:0] req, input logic [POS_W-1:0] pos,
	                             input logic [VAL_W-1:0] val);
		logic [CNT_W-1:0] cap;
		outcome_t         o;
		int               i;
		cap      = usable_cap(cap_raw);
		o        = '0;
		o.status = ST_OK;
		case (req)
			REQ_INSERT: begin
				if (pos >= cap)
					o.status = ST_BADPOS;
				else if (n_held >= cap)
					o.status = ST_FULL;
				else if (pos > n_held)
					o.status = ST_BADPOS;
				else begin
					for (i = int'(n_held); i > pos; i--)
						entries[i] = entries[i-1];
					entries[pos] = val;
					n_held       = n_held + CNT_W'(1);
				end
			end
			REQ_REMOVE: begin
				if (pos >= cap)
					o.status = ST_BADPOS;
				else if (n_held == '0)
					o.status = ST_EMPTY;
				else if (pos >= n_held)
					o.status = ST_BADPOS;
				else begin
					for (i = int'(pos); i + 1 < n_held; i++)
						entries[i] = entries[i+1];
					n_held = n_held - CNT_W'(1);
				end
			end
			REQ_READ: begin
				if (n_held == '0)
					o.status = ST_EMPTY;
				else if (pos >= n_held)
					o.status = ST_BADPOS;
				else
					o.value = entries[pos];
			end
			default: begin
				n_held = '0;
			end
		endcase
		o.count = n_held;
		o.full  = (n_held >= cap);
		o.empty = (n_held == '0);
		expected_q.push_back(o);
	endtask

	task automatic check_field(input string name, input logic [VAL_W-1:0] want,
	                           input logic [VAL_W-1:0] got);
		if (want !== got) begin
			fail_total++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
		end
	endtask

	task automatic check_result();
		outcome_t want;
		if (expected_q.size() == 0) begin
			fail_total++;
			$display("%0t: result item with none expected, expected none, actual %h %h",
			         $time, m_tdata, m_tuser);
		end else begin
			want = expected_q.pop_front();
			check_field("status", VAL_W'(want.status), VAL_W'(m_tdata[1:0]));
			check_field("read_value", want.value, m_tdata[33:2]);
			check_field("entry_count", VAL_W'(want.count), VAL_W'(m_tdata[40:34]));
			check_field("is_full", VAL_W'(want.full), VAL_W'(m_tuser[0]));
			check_field("is_empty", VAL_W'(want.empty), VAL_W'(m_tuser[1]));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fail_total = 0;
			n_held     = '0;
			cap_raw    = CAP_RESET;
			expected_q.delete();
		end else begin
			if (m_tvalid && m_tready)
				check_result();
			if (s_tvalid && s_tready)
				apply_request(s_tuser[REQ_W-1:0], s_tdata[5:0], s_tdata[37:6]);
			if (psel && penable && pready && paddr == CAP_ADDR) begin
				if (pwrite)
					cap_raw = pwdata[CNT_W-1:0];
				else
					check_field("capacity", VAL_W'(cap_raw), prdata);
			end
		end
		outstanding <= expected_q.size();
		level       <= n_held;
	end

endmodule

/* test/tb_fixed_capacity_insert_list_core.sv */
// ----------------------------------------------------------------------------
// Insert list core testbench
// Drives requests into the insert list core with random gaps while the
// result side stalls at random. A directed opening covers empty, full and
// bad position cases, the value extremes and capacity values that clamp.
// Random phases then run under several capacities, one of them below the
// entry count. The checker beside the core predicts and compares; this
// module only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_fixed_capacity_insert_list_core;
	import ficl_pkg::*;

	localparam logic [PADDR_W-1:0] CAP_ADDR    = '0;
	localparam int                 CYCLE_LIMIT = 400000;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic [S_TDATA_W-1:0] s_tdata  = '0;
	logic [S_TUSER_W-1:0] s_tuser  = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [M_TUSER_W-1:0] m_tuser;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic                 psel     = 1'b0;
	logic                 penable  = 1'b0;
	logic                 pwrite   = 1'b0;
	logic [PADDR_W-1:0]   paddr    = '0;
	logic [PDATA_W-1:0]   pwdata   = '0;
	logic [PDATA_W-1:0]   prdata;
	logic                 pready;

	int                   fail_total;
	int                   outstanding;
	logic [CNT_W-1:0]     level;
	int                   cycles     = 0;
	int                   stall_left = 0;
	bit                   rx_steady  = 1'b0;
	bit                   tx_burst   = 1'b0;
	bit                   tx_up      = 1'b0;

	fixed_capacity_insert_list_core uut (
		.clk(clk), .arst_n(arst_n),
		.s_tdata(s_tdata), .s_tuser(s_tuser), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.m_tdata(m_tdata), .m_tuser(m_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	ficl_result_checker #(.CAP_ADDR(CAP_ADDR)) u_result_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tdata(s_tdata), .s_tuser(s_tuser), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.m_tdata(m_tdata), .m_tuser(m_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.fail_total(fail_total), .outstanding(outstanding), .level(level)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// The result side alternates between stretches with no stalls and stretches
	// with random stalls, mostly short ones.
	always @(posedge clk) begin
		if (cycles % 300 == 0)
			rx_steady <= ($urandom_range(0, 3) == 0);
		if (stall_left > 0) begin
			m_tready   <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!rx_steady && $urandom_range(0, 99) < 25) begin
			m_tready   <= 1'b0;
			stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30)
			                                          : $urandom_range(0, 2);
		end else begin
			m_tready <= 1'b1;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (tx_burst || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 20);
	endfunction

	function automatic logic [POS_W-1:0] pick_pos();
		int r;
		int hi;
		r  = $urandom_range(0, 99);
		hi = (level > 63) ? 63 : level;
		if (r < 65)
			return POS_W'($urandom_range(0, hi));
		if (r < 75)
			return '0;
		if (r < 85)
			return POS_W'(hi);
		return POS_W'($urandom_range(0, 63));
	endfunction

	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 39))
			0:       return 32'h8000_0000;
			1:       return 32'h7FFF_FFFF;
			2:       return 32'h0000_0000;
			3:       return 32'hFFFF_FFFF;
			default: return $urandom();
		endcase
	endfunction

	task automatic send_request(input logic [REQ_W-1:0] req, input logic [POS_W-1:0] pos,
	                            input logic [VAL_W-1:0] val);
		int gap;
		s_tuser  <= req;
		s_tdata  <= {2'b00, val, pos};
		s_tvalid <= 1'b1;
		tx_up = 1'b1;
		do @(posedge clk); while (!s_tready);
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			tx_up = 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		if (tx_up) begin
			s_tvalid <= 1'b0;
			tx_up = 1'b0;
		end
		do @(posedge clk); while (outstanding != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [PDATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= CAP_ADDR;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_capacity(input logic [CNT_W-1:0] cap);
		logic [PDATA_W-1:0] data;
		data          = $urandom();
		data[CNT_W-1:0] = cap;
		apb_access(1'b1, data);
		apb_access(1'b0, '0);
	endtask

	task automatic run_phase(input int n, input int ins_pct, input int rem_pct,
	                         input int clr_pct, input bit burst);
		int               r;
		logic [REQ_W-1:0] req;
		tx_burst = burst;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			if (r < ins_pct)
				req = REQ_INSERT;
			else if (r < ins_pct + rem_pct)
				req = REQ_REMOVE;
			else if (r < ins_pct + rem_pct + clr_pct)
				req = REQ_CLEAR;
			else
				req = REQ_READ;
			send_request(req, pick_pos(), pick_value());
		end
		wait_idle();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		apb_access(1'b0, '0);

		send_request(REQ_READ, 6'd0, 32'd0);
		send_request(REQ_REMOVE, 6'd0, 32'd0);
		send_request(REQ_INSERT, 6'd1, 32'd5);
		send_request(REQ_INSERT, 6'd0, 32'h8000_0000);
		send_request(REQ_INSERT, 6'd1, 32'h7FFF_FFFF);
		send_request(REQ_INSERT, 6'd0, 32'hFFFF_FFFF);
		send_request(REQ_INSERT, 6'd63, 32'd0);
		send_request(REQ_READ, 6'd0, 32'd0);
		send_request(REQ_READ, 6'd2, 32'd0);
		send_request(REQ_READ, 6'd3, 32'd0);
		send_request(REQ_READ, 6'd63, 32'd0);
		send_request(REQ_REMOVE, 6'd1, 32'd0);
		send_request(REQ_REMOVE, 6'd2, 32'd0);
		send_request(REQ_CLEAR, 6'd0, 32'd0);
		send_request(REQ_READ, 6'd0, 32'd0);
		send_request(REQ_CLEAR, 6'd0, 32'd0);
		wait_idle();

		set_capacity(7'd2);
		send_request(REQ_INSERT, 6'd0, 32'h1234_5678);
		send_request(REQ_INSERT, 6'd1, 32'd0);
		send_request(REQ_INSERT, 6'd0, 32'd5);
		send_request(REQ_INSERT, 6'd2, 32'd7);
		send_request(REQ_REMOVE, 6'd2, 32'd0);
		wait_idle();

		// A capacity of zero acts as one, so the two entries held make the list full.
		set_capacity(7'd0);
		send_request(REQ_INSERT, 6'd0, 32'd9);
		send_request(REQ_REMOVE, 6'd1, 32'd0);
		send_request(REQ_READ, 6'd1, 32'd0);
		send_request(REQ_REMOVE, 6'd0, 32'd0);
		send_request(REQ_INSERT, 6'd0, 32'd1);
		send_request(REQ_CLEAR, 6'd0, 32'd0);
		wait_idle();

		set_capacity(7'd127);
		run_phase(160, 75, 10, 0, 1'b0);
		set_capacity(7'd5);
		run_phase(80, 30, 30, 0, 1'b0);
		set_capacity(7'd1);
		run_phase(80, 45, 30, 3, 1'b1);
		set_capacity(CNT_W'($urandom_range(1, 127)));
		run_phase(100, 50, 30, 2, 1'b0);
		set_capacity(CNT_W'($urandom_range(2, 10)));
		run_phase(100, 45, 35, 3, 1'b0);
		set_capacity(7'd64);
		run_phase(120, 70, 15, 0, 1'b1);
		set_capacity(7'd0);
		run_phase(60, 40, 40, 5, 1'b0);
		set_capacity(7'd64);
		run_phase(100, 45, 35, 3, 1'b0);

		repeat (6) @(posedge clk);
		if (fail_total == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
